// ===== sv/scmr_pkg.sv =====
// shared types and constants of the sound channel mixer register unit
// no dependencies; imported by every module of the block
`default_nettype none

package scmr_pkg;

    // bus request codes
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_IDLE  = 2'd3
    } scmr_action_t;

    // register addresses
    localparam logic [15:0] ADDR_VOLUME = 16'hff24;
    localparam logic [15:0] ADDR_PAN    = 16'hff25;
    localparam logic [15:0] ADDR_STATUS = 16'hff26;

    // read values
    localparam logic [7:0] READ_UNMAPPED = 8'hff;
    localparam logic [2:0] STATUS_FILL   = 3'b111;

    localparam int unsigned LEVEL_W  = 4;
    localparam int unsigned SAMPLE_W = 14;

    // mix offset, already halved: (s*512 - 16384) / 2 == s*256 - 8192
    localparam logic [SAMPLE_W-1:0] CENTER_OFFSET = 14'd8192;
    // side offset before gain
    localparam logic signed [15:0] SIDE_OFFSET = 16'sd16384;

    // control registers as seen by the mixer and the read path
    typedef struct packed {
        logic       master_on;
        logic       left_vin;
        logic [2:0] left_gain;
        logic       right_vin;
        logic [2:0] right_gain;
        logic [7:0] pan_mask;
    } scmr_ctrl_t;

    // one request held in the input register
    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        address;
        logic [7:0]         write_data;
        logic [LEVEL_W-1:0] square1_level;
        logic [LEVEL_W-1:0] square2_level;
        logic [LEVEL_W-1:0] wave_level;
        logic [LEVEL_W-1:0] noise_level;
        logic [3:0]         channel_active;
    } scmr_item_t;

endpackage

`default_nettype wire

// ===== sv/scmr_mixer.sv =====
// combinational mixer: center, left and right samples from four channel levels
// depends on scmr_pkg for the control struct and offsets
`default_nettype none

module scmr_mixer
(
    input  wire logic [scmr_pkg::LEVEL_W-1:0]         square1_level,
    input  wire logic [scmr_pkg::LEVEL_W-1:0]         square2_level,
    input  wire logic [scmr_pkg::LEVEL_W-1:0]         wave_level,
    input  wire logic [scmr_pkg::LEVEL_W-1:0]         noise_level,
    input  wire scmr_pkg::scmr_ctrl_t                 ctrl,
    output logic signed [scmr_pkg::SAMPLE_W-1:0]      center_mix,
    output logic signed [scmr_pkg::SAMPLE_W-1:0]      left_mix,
    output logic signed [scmr_pkg::SAMPLE_W-1:0]      right_mix
);
    import scmr_pkg::*;

    logic [5:0]         all_sum;
    logic [5:0]         left_sum;
    logic [5:0]         right_sum;
    logic signed [15:0] left_base;
    logic signed [15:0] right_base;
    logic signed [4:0]  left_mult;
    logic signed [4:0]  right_mult;
    logic signed [20:0] left_prod;
    logic signed [20:0] right_prod;

    function automatic logic [5:0] pick_sum(input logic [3:0] sel,
                                            input logic [3:0] l0,
                                            input logic [3:0] l1,
                                            input logic [3:0] l2,
                                            input logic [3:0] l3);
        logic [5:0] acc;
        acc = 6'd0;
        if (sel[0]) acc = acc + {2'b00, l0};
        if (sel[1]) acc = acc + {2'b00, l1};
        if (sel[2]) acc = acc + {2'b00, l2};
        if (sel[3]) acc = acc + {2'b00, l3};
        return acc;
    endfunction

    always_comb
    begin
        all_sum   = pick_sum(4'hf, square1_level, square2_level, wave_level, noise_level);
        left_sum  = pick_sum(ctrl.pan_mask[7:4], square1_level, square2_level,
                             wave_level, noise_level);
        right_sum = pick_sum(ctrl.pan_mask[3:0], square1_level, square2_level,
                             wave_level, noise_level);

        center_mix = $signed({all_sum, 8'b0} - CENTER_OFFSET);

        left_base  = $signed({1'b0, left_sum, 9'b0}) - SIDE_OFFSET;
        right_base = $signed({1'b0, right_sum, 9'b0}) - SIDE_OFFSET;
        left_mult  = $signed({1'b0, {1'b0, ctrl.left_gain} + 4'd1});
        right_mult = $signed({1'b0, {1'b0, ctrl.right_gain} + 4'd1});
        left_prod  = 21'(left_base) * 21'(left_mult);
        right_prod = 21'(right_base) * 21'(right_mult);

        // base is a multiple of 512, so /8 then floor /2 is an exact shift by 4
        left_mix  = $signed(left_prod[17:4]);
        right_mix = $signed(right_prod[17:4]);
    end

endmodule

`default_nettype wire

// ===== sv/scmr_regs.sv =====
// volume, panning and master status registers with read mux and power pulses
// depends on scmr_pkg for codes, addresses and the control struct
`default_nettype none

module scmr_regs
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 commit,
    input  wire logic [1:0]           action,
    input  wire logic [15:0]          address,
    input  wire logic [7:0]           write_data,
    input  wire logic [3:0]           channel_active,
    output scmr_pkg::scmr_ctrl_t      ctrl,
    output logic [7:0]                read_data,
    output logic                      power_down,
    output logic                      phase_reset
);
    import scmr_pkg::*;

    scmr_ctrl_t ctrl_reg;
    scmr_ctrl_t ctrl_next;

    assign ctrl = ctrl_reg;

    always_comb
    begin
        ctrl_next   = ctrl_reg;
        read_data   = 8'h00;
        power_down  = 1'b0;
        phase_reset = 1'b0;
        unique case (scmr_action_t'(action))
            ACT_READ:
            begin
                unique case (address)
                    ADDR_VOLUME: read_data = {ctrl_reg.left_vin, ctrl_reg.left_gain,
                                              ctrl_reg.right_vin, ctrl_reg.right_gain};
                    ADDR_PAN:    read_data = ctrl_reg.pan_mask;
                    ADDR_STATUS: read_data = {ctrl_reg.master_on, STATUS_FILL,
                                              channel_active};
                    default:     read_data = READ_UNMAPPED;
                endcase
            end
            ACT_WRITE:
            begin
                unique case (address)
                    ADDR_VOLUME:
                    begin
                        ctrl_next.left_vin   = write_data[7];
                        ctrl_next.left_gain  = write_data[6:4];
                        ctrl_next.right_vin  = write_data[3];
                        ctrl_next.right_gain = write_data[2:0];
                    end
                    ADDR_PAN: ctrl_next.pan_mask = write_data;
                    ADDR_STATUS:
                    begin
                        if (ctrl_reg.master_on && !write_data[7])
                        begin
                            // master off wipes every register
                            ctrl_next  = '0;
                            power_down = 1'b1;
                        end
                        else if (!ctrl_reg.master_on && write_data[7])
                        begin
                            ctrl_next.master_on = 1'b1;
                            phase_reset         = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_TICK: ;
            ACT_IDLE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (commit)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sound_channel_mixer_registers_unit.sv =====
// top level of the sound channel mixer register unit: input register, result register
// depends on scmr_pkg, scmr_regs and scmr_mixer
`default_nettype none

// Four-channel sound mixer with its volume (0xff24), panning (0xff25) and
// master status (0xff26) registers. Every request (mix tick, register read,
// register write or idle) yields exactly one result, in order. A request goes
// into an input register, is processed by short logic (register decode,
// four-level adders and a 16x5 gain multiply) and lands in a result register;
// the unit sustains one request per clock while out_ready is high. The
// input register takes a request while a finished result waits for out_ready
// only if it is empty; once both registers hold a request, a stall downstream
// holds off the input in the same cycle.
// Mixed samples are held in the result register and shown with every result
// until the next tick or a master power-down clears them. read_data is zero
// for anything but a read; power_down_pulse and phase_reset_pulse flag master
// enable transitions caused by that request's status write.
module sound_channel_mixer_registers_unit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       action,
    input  wire logic [15:0]                      address,
    input  wire logic [7:0]                       write_data,
    input  wire logic [3:0]                       square1_level,
    input  wire logic [3:0]                       square2_level,
    input  wire logic [3:0]                       wave_level,
    input  wire logic [3:0]                       noise_level,
    input  wire logic [3:0]                       channel_active,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [7:0]                            read_data,
    output logic signed [13:0]                    center_sample,
    output logic signed [13:0]                    left_sample,
    output logic signed [13:0]                    right_sample,
    output logic                                  power_down_pulse,
    output logic                                  phase_reset_pulse
);
    import scmr_pkg::*;

    // input register
    logic       s1_valid_reg;
    logic       s1_valid_next;
    scmr_item_t s1_item_reg;

    // result register (samples double as the held mix state)
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [7:0]                 rd_reg;
    logic signed [SAMPLE_W-1:0] center_reg;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;
    logic signed [SAMPLE_W-1:0] center_next;
    logic signed [SAMPLE_W-1:0] left_next;
    logic signed [SAMPLE_W-1:0] right_next;
    logic                       pdown_reg;
    logic                       preset_reg;

    logic in_fire;
    logic s1_advance;

    scmr_ctrl_t                 ctrl;
    logic [7:0]                 rd_comb;
    logic                       pdown_comb;
    logic                       preset_comb;
    logic signed [SAMPLE_W-1:0] center_mix;
    logic signed [SAMPLE_W-1:0] left_mix;
    logic signed [SAMPLE_W-1:0] right_mix;

    // handshake: input stage moves whenever the result slot is free or draining
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // register file, updated when the request commits to the result register
    scmr_regs u_regs
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .commit         (s1_advance),
        .action         (s1_item_reg.action),
        .address        (s1_item_reg.address),
        .write_data     (s1_item_reg.write_data),
        .channel_active (s1_item_reg.channel_active),
        .ctrl           (ctrl),
        .read_data      (rd_comb),
        .power_down     (pdown_comb),
        .phase_reset    (preset_comb)
    );

    // mix datapath, uses register values from before this request
    scmr_mixer u_mixer
    (
        .square1_level (s1_item_reg.square1_level),
        .square2_level (s1_item_reg.square2_level),
        .wave_level    (s1_item_reg.wave_level),
        .noise_level   (s1_item_reg.noise_level),
        .ctrl          (ctrl),
        .center_mix    (center_mix),
        .left_mix      (left_mix),
        .right_mix     (right_mix)
    );

    // held sample update
    always_comb
    begin
        center_next = center_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        priority if (scmr_action_t'(s1_item_reg.action) == ACT_TICK)
        begin
            // tick with master off zeroes the mix
            center_next = ctrl.master_on ? center_mix : '0;
            left_next   = ctrl.master_on ? left_mix   : '0;
            right_next  = ctrl.master_on ? right_mix  : '0;
        end
        else if (pdown_comb)
        begin
            center_next = '0;
            left_next   = '0;
            right_next  = '0;
        end
        else
        begin
            center_next = center_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_reg        <= 8'h00;
            center_reg    <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            pdown_reg     <= 1'b0;
            preset_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                rd_reg     <= rd_comb;
                center_reg <= center_next;
                left_reg   <= left_next;
                right_reg  <= right_next;
                pdown_reg  <= pdown_comb;
                preset_reg <= preset_comb;
            end
        end
    end

    // request payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.action         <= action;
            s1_item_reg.address        <= address;
            s1_item_reg.write_data     <= write_data;
            s1_item_reg.square1_level  <= square1_level;
            s1_item_reg.square2_level  <= square2_level;
            s1_item_reg.wave_level     <= wave_level;
            s1_item_reg.noise_level    <= noise_level;
            s1_item_reg.channel_active <= channel_active;
        end
    end

    assign out_valid         = out_valid_reg;
    assign read_data         = rd_reg;
    assign center_sample     = center_reg;
    assign left_sample       = left_reg;
    assign right_sample      = right_reg;
    assign power_down_pulse  = pdown_reg;
    assign phase_reset_pulse = preset_reg;

    // both transitions cannot come from one request
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid_reg && pdown_reg && preset_reg))
        else $error("power-down and phase-reset flagged together");

    // master dropping must be reported by the committed result
    a_fall_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(ctrl.master_on) |-> (out_valid_reg && pdown_reg))
        else $error("master enable fell without power-down flag");

    // a power-down result carries cleared samples
    a_pdown_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pdown_reg) |->
        (center_reg == '0 && left_reg == '0 && right_reg == '0))
        else $error("samples not cleared on power-down");

    // master on means a phase reset was reported when it rose
    a_rise_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ctrl.master_on) |-> (out_valid_reg && preset_reg))
        else $error("master enable rose without phase-reset flag");

endmodule

`default_nettype wire
